// File: src/btpc_pkg.sv
// Shared widths, register indexes and inter-stage types of the compensation pipeline.
`default_nettype none
package btpc_pkg;

    localparam int RAW_W      = 20;
    localparam int TC_W       = 15;
    localparam int TF_W       = 20;
    localparam int PRES_W     = 25;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 48;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 64;

    localparam int TF_MIN   = -524288;
    localparam int TF_MAX   = 524287;
    localparam int TC_MIN   = -4000;
    localparam int TC_MAX   = 8500;
    localparam int PRES_MAX = 33554431;

    localparam int DIV_W      = 64;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = DIV_W / DIV_STEP;

    localparam logic [CFG_IDX_W-1:0] REG_TEMP = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLO  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PMID = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PHI  = 8'd3;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } coef_t;

    typedef struct packed {
        logic signed [TC_W-1:0] tc;
        logic signed [TF_W-1:0] tf;
    } side_t;

    typedef struct packed {
        logic signed [20:0]  pv1;
        logic [RAW_W-1:0]    ap;
        side_t               side;
    } tout_t;

    typedef struct packed {
        logic [DIV_W-1:0] mn;
        logic [30:0]      md;
        logic             neg;
        logic             dz;
        side_t            side;
    } dvin_t;

    typedef struct packed {
        logic [DIV_W-1:0] w;
        logic             neg;
        logic             dz;
        side_t            side;
    } dvout_t;

    typedef struct packed {
        logic signed [TC_W-1:0] tc;
        logic signed [TF_W-1:0] tf;
        logic [PRES_W-1:0]      pres;
        logic                   pvld;
    } res_t;

endpackage
`default_nettype wire

// File: src/btpc_temp.sv
// Temperature stages: raw reading to fine temperature, centi-degrees and pressure offset.
`default_nettype none
module btpc_temp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          adv,
    input  wire logic                          in_valid,
    input  wire logic [btpc_pkg::RAW_W-1:0]    in_at,
    input  wire logic [btpc_pkg::RAW_W-1:0]    in_ap,
    input  wire btpc_pkg::coef_t               coef,
    output logic                               out_valid,
    output btpc_pkg::tout_t                    out_data
);

    logic [4:0] vld_reg;

    logic [btpc_pkg::RAW_W-1:0] at0_reg;
    logic [btpc_pkg::RAW_W-1:0] ap0_reg, ap1_reg, ap2_reg, ap3_reg, ap4_reg;
    logic signed [34:0] m1_reg, m1_next;
    logic signed [35:0] bb_reg, bb_next;
    logic signed [23:0] v1t_reg, v1t_next;
    logic signed [39:0] m2_reg, m2_next;
    logic signed [btpc_pkg::TF_W-1:0] tf3_reg, tf3_next, tf4_reg;
    logic signed [btpc_pkg::TC_W-1:0] tc4_reg, tc4_next;
    logic signed [20:0] pv1_reg, pv1_next;

    logic signed [18:0] a_s;
    logic signed [17:0] b_s;
    logic signed [23:0] bbs;
    logic signed [26:0] tfw;
    logic signed [22:0] tc5;
    logic signed [btpc_pkg::TC_W-1:0] tcw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_comb begin
        a_s      = $signed({2'b00, at0_reg[19:3]}) - $signed({2'b00, coef.t1, 1'b0});
        b_s      = $signed({2'b00, at0_reg[19:4]}) - $signed({2'b00, coef.t1});
        m1_next  = a_s * $signed(coef.t2);
        bb_next  = b_s * b_s;
        v1t_next = 24'(m1_reg >>> 11);
        bbs      = 24'(bb_reg >>> 12);
        m2_next  = bbs * $signed(coef.t3);
        tfw      = 27'(m2_reg >>> 14) + 27'(v1t_reg);
        if (tfw < btpc_pkg::TF_MIN) begin
            tf3_next = btpc_pkg::TF_W'(btpc_pkg::TF_MIN);
        end else if (tfw > btpc_pkg::TF_MAX) begin
            tf3_next = btpc_pkg::TF_W'(btpc_pkg::TF_MAX);
        end else begin
            tf3_next = tfw[btpc_pkg::TF_W-1:0];
        end
        tc5 = (23'(tf3_reg) * 23'sd5) + 23'sd128;
        tcw = btpc_pkg::TC_W'(tc5 >>> 8);
        if (tcw < btpc_pkg::TC_MIN) begin
            tc4_next = btpc_pkg::TC_W'(btpc_pkg::TC_MIN);
        end else if (tcw > btpc_pkg::TC_MAX) begin
            tc4_next = btpc_pkg::TC_W'(btpc_pkg::TC_MAX);
        end else begin
            tc4_next = tcw;
        end
        pv1_next = 21'(tf3_reg) - 21'sd128000;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            at0_reg <= in_at;
            ap0_reg <= in_ap;
            m1_reg  <= m1_next;
            bb_reg  <= bb_next;
            ap1_reg <= ap0_reg;
            v1t_reg <= v1t_next;
            m2_reg  <= m2_next;
            ap2_reg <= ap1_reg;
            tf3_reg <= tf3_next;
            ap3_reg <= ap2_reg;
            tc4_reg <= tc4_next;
            tf4_reg <= tf3_reg;
            pv1_reg <= pv1_next;
            ap4_reg <= ap3_reg;
        end
    end

    assign out_valid        = vld_reg[4];
    assign out_data.pv1     = pv1_reg;
    assign out_data.ap      = ap4_reg;
    assign out_data.side.tc = tc4_reg;
    assign out_data.side.tf = tf4_reg;

endmodule
`default_nettype wire

// File: src/btpc_press.sv
// Pressure front stages: offset polynomial, divisor and numerator, sign split for the divider.
`default_nettype none
module btpc_press (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            adv,
    input  wire logic            in_valid,
    input  wire btpc_pkg::tout_t in_data,
    input  wire btpc_pkg::coef_t coef,
    output logic                 out_valid,
    output btpc_pkg::dvin_t      out_data
);

    logic [5:0] vld_reg;

    btpc_pkg::side_t side5_reg, side6_reg, side7_reg, side8_reg, side9_reg, side10_reg;
    logic [btpc_pkg::RAW_W-1:0] ap5_reg, ap6_reg;

    logic signed [40:0] sq_reg, sq_next;
    logic signed [36:0] vp5_reg, vp5_next, vp2_reg, vp2_next;
    logic signed [56:0] x6_reg, x6_next, x3_reg, x3_next;
    logic signed [36:0] vp5b_reg, vp2b_reg;
    logic signed [57:0] v2_reg, v2_next;
    logic signed [50:0] x_reg, x_next;
    logic [20:0] pr_reg, pr_next;
    logic signed [67:0] y_full;
    logic signed [59:0] d_reg, d_next;
    logic [30:0] vd8_reg, vd8_next, vd9_reg;
    logic signed [72:0] n_full;
    logic [63:0] n_reg, n_next;
    logic [63:0] mn_reg, mn_next;
    logic [30:0] md_reg, md_next;
    logic neg_reg, neg_next, dz_reg, dz_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_comb begin
        sq_next  = in_data.pv1 * in_data.pv1;
        vp5_next = in_data.pv1 * $signed(coef.p5);
        vp2_next = in_data.pv1 * $signed(coef.p2);
        x6_next  = sq_reg * $signed(coef.p6);
        x3_next  = sq_reg * $signed(coef.p3);
        v2_next  = 58'(x6_reg) + (58'(vp5b_reg) <<< 17) + (58'($signed(coef.p4)) <<< 35);
        x_next   = 51'(x3_reg >>> 8) + (51'(vp2b_reg) <<< 12) + (51'sd1 <<< 47);
        pr_next  = 21'd1048576 - 21'(ap6_reg);
        y_full   = x_reg * $signed({1'b0, coef.p1});
        vd8_next = y_full[63:33];
        d_next   = $signed({8'b0, pr_reg, 31'b0}) - 60'(v2_reg);
        n_full   = d_reg * $signed(13'd3125);
        n_next   = n_full[63:0];
        mn_next  = n_reg[63] ? (64'd0 - n_reg) : n_reg;
        md_next  = vd9_reg[30] ? (31'd0 - vd9_reg) : vd9_reg;
        neg_next = n_reg[63] ^ vd9_reg[30];
        dz_next  = (vd9_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_reg     <= sq_next;
            vp5_reg    <= vp5_next;
            vp2_reg    <= vp2_next;
            ap5_reg    <= in_data.ap;
            side5_reg  <= in_data.side;
            x6_reg     <= x6_next;
            x3_reg     <= x3_next;
            vp5b_reg   <= vp5_reg;
            vp2b_reg   <= vp2_reg;
            ap6_reg    <= ap5_reg;
            side6_reg  <= side5_reg;
            v2_reg     <= v2_next;
            x_reg      <= x_next;
            pr_reg     <= pr_next;
            side7_reg  <= side6_reg;
            d_reg      <= d_next;
            vd8_reg    <= vd8_next;
            side8_reg  <= side7_reg;
            n_reg      <= n_next;
            vd9_reg    <= vd8_reg;
            side9_reg  <= side8_reg;
            mn_reg     <= mn_next;
            md_reg     <= md_next;
            neg_reg    <= neg_next;
            dz_reg     <= dz_next;
            side10_reg <= side9_reg;
        end
    end

    assign out_valid     = vld_reg[5];
    assign out_data.mn   = mn_reg;
    assign out_data.md   = md_reg;
    assign out_data.neg  = neg_reg;
    assign out_data.dz   = dz_reg;
    assign out_data.side = side10_reg;

endmodule
`default_nettype wire

// File: src/btpc_div.sv
// Pipelined restoring divider: 64-bit magnitude by 31-bit magnitude, four quotient bits a stage.
`default_nettype none
module btpc_div (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            adv,
    input  wire logic            in_valid,
    input  wire btpc_pkg::dvin_t in_data,
    output logic                 out_valid,
    output btpc_pkg::dvout_t     out_data
);

    localparam int NS = btpc_pkg::DIV_STAGES;

    logic [NS-1:0] vld_reg;
    logic [30:0]   rem_reg  [NS];
    logic [63:0]   wrd_reg  [NS];
    logic [30:0]   md_reg   [NS];
    logic          neg_reg  [NS];
    logic          dz_reg   [NS];
    btpc_pkg::side_t side_reg [NS];

    logic [30:0] rem_in   [NS];
    logic [63:0] wrd_in   [NS];
    logic [30:0] md_in    [NS];
    logic [30:0] rem_next [NS];
    logic [63:0] wrd_next [NS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    always_comb begin
        logic [31:0] r32;
        logic [30:0] r;
        logic [63:0] w;
        logic        ge;
        rem_in[0] = '0;
        wrd_in[0] = in_data.mn;
        md_in[0]  = in_data.md;
        for (int s = 1; s < NS; s++) begin
            rem_in[s] = rem_reg[s-1];
            wrd_in[s] = wrd_reg[s-1];
            md_in[s]  = md_reg[s-1];
        end
        for (int s = 0; s < NS; s++) begin
            r = rem_in[s];
            w = wrd_in[s];
            for (int k = 0; k < btpc_pkg::DIV_STEP; k++) begin
                r32 = {r, w[63]};
                ge  = (r32 >= {1'b0, md_in[s]});
                w   = {w[62:0], ge};
                r   = ge ? 31'(r32 - {1'b0, md_in[s]}) : r32[30:0];
            end
            rem_next[s] = r;
            wrd_next[s] = w;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int s = 0; s < NS; s++) begin
                rem_reg[s] <= rem_next[s];
                wrd_reg[s] <= wrd_next[s];
                md_reg[s]  <= md_in[s];
            end
            neg_reg[0]  <= in_data.neg;
            dz_reg[0]   <= in_data.dz;
            side_reg[0] <= in_data.side;
            for (int s = 1; s < NS; s++) begin
                neg_reg[s]  <= neg_reg[s-1];
                dz_reg[s]   <= dz_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign out_valid     = vld_reg[NS-1];
    assign out_data.w    = wrd_reg[NS-1];
    assign out_data.neg  = neg_reg[NS-1];
    assign out_data.dz   = dz_reg[NS-1];
    assign out_data.side = side_reg[NS-1];

endmodule
`default_nettype wire

// File: src/btpc_post.sv
// Pressure back stages: signed quotient, wrapping 64-bit products, final sum and clamp.
`default_nettype none
module btpc_post (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             adv,
    input  wire logic             in_valid,
    input  wire btpc_pkg::dvout_t in_data,
    input  wire btpc_pkg::coef_t  coef,
    output logic                  out_valid,
    output btpc_pkg::res_t        out_data
);

    logic [6:0] vld_reg;

    btpc_pkg::side_t side0_reg, side1_reg, side2_reg, side3_reg, side4_reg, side5_reg;
    logic dz0_reg, dz1_reg, dz2_reg, dz3_reg, dz4_reg, dz5_reg;

    logic [63:0] q0_reg, q0_next, q1_reg, q2_reg, q3_reg, q4_reg;
    logic [63:0] a;
    logic [63:0] y8, y9;
    logic [63:0] aall_reg, aall_next;
    logic [31:0] aac_reg, aac_next;
    logic [63:0] p8ll_reg, p8ll_next;
    logic [31:0] p8c_reg, p8c_next;
    logic [63:0] sq_reg, sq_next, pp2_reg, pp2_next, pp3_reg, pp4_reg;
    logic [63:0] p9ll_reg, p9ll_next;
    logic [31:0] p9c_reg, p9c_next;
    logic [63:0] t9_reg, t9_next;
    logic [63:0] s_reg, s_next;
    logic [63:0] r;
    btpc_pkg::res_t res_reg, res_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[5:0], in_valid};
        end
    end

    always_comb begin
        q0_next   = in_data.neg ? (64'd0 - in_data.w) : in_data.w;

        a         = $signed(q0_reg) >>> 13;
        y8        = {{48{coef.p8[15]}}, coef.p8};
        aall_next = a[31:0] * a[31:0];
        aac_next  = 32'(a[63:32] * a[31:0]);
        p8ll_next = q0_reg[31:0] * y8[31:0];
        p8c_next  = 32'(q0_reg[63:32] * y8[31:0]) + 32'(q0_reg[31:0] * y8[63:32]);

        sq_next   = aall_reg + {aac_reg[30:0], 33'b0};
        pp2_next  = p8ll_reg + {p8c_reg, 32'b0};

        y9        = {{48{coef.p9[15]}}, coef.p9};
        p9ll_next = sq_reg[31:0] * y9[31:0];
        p9c_next  = 32'(sq_reg[63:32] * y9[31:0]) + 32'(sq_reg[31:0] * y9[63:32]);

        t9_next   = p9ll_reg + {p9c_reg, 32'b0};

        s_next    = q4_reg + 64'($signed(t9_reg) >>> 25) + 64'($signed(pp4_reg) >>> 19);

        r         = 64'($signed(s_reg) >>> 8) + {{44{coef.p7[15]}}, coef.p7, 4'b0};
        res_next.tc = side5_reg.tc;
        res_next.tf = side5_reg.tf;
        if (dz5_reg) begin
            res_next.pres = '0;
            res_next.pvld = 1'b0;
        end else begin
            res_next.pvld = 1'b1;
            if (r[63]) begin
                res_next.pres = '0;
            end else if (|r[62:btpc_pkg::PRES_W]) begin
                res_next.pres = btpc_pkg::PRES_W'(btpc_pkg::PRES_MAX);
            end else begin
                res_next.pres = r[btpc_pkg::PRES_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            q0_reg    <= q0_next;
            dz0_reg   <= in_data.dz;
            side0_reg <= in_data.side;
            aall_reg  <= aall_next;
            aac_reg   <= aac_next;
            p8ll_reg  <= p8ll_next;
            p8c_reg   <= p8c_next;
            q1_reg    <= q0_reg;
            dz1_reg   <= dz0_reg;
            side1_reg <= side0_reg;
            sq_reg    <= sq_next;
            pp2_reg   <= pp2_next;
            q2_reg    <= q1_reg;
            dz2_reg   <= dz1_reg;
            side2_reg <= side1_reg;
            p9ll_reg  <= p9ll_next;
            p9c_reg   <= p9c_next;
            pp3_reg   <= pp2_reg;
            q3_reg    <= q2_reg;
            dz3_reg   <= dz2_reg;
            side3_reg <= side2_reg;
            t9_reg    <= t9_next;
            pp4_reg   <= pp3_reg;
            q4_reg    <= q3_reg;
            dz4_reg   <= dz3_reg;
            side4_reg <= side3_reg;
            s_reg     <= s_next;
            dz5_reg   <= dz4_reg;
            side5_reg <= side4_reg;
            res_reg   <= res_next;
        end
    end

    assign out_valid = vld_reg[6];
    assign out_data  = res_reg;

endmodule
`default_nettype wire

// File: src/btpc_outq.sv
// Output register with one skid entry; holds the pipeline only when both are full.
`default_nettype none
module btpc_outq (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    input  wire btpc_pkg::res_t in_data,
    input  wire logic           m_tready,
    output logic                adv,
    output logic                m_valid,
    output btpc_pkg::res_t      m_data
);

    logic out_v_reg, out_v_next;
    logic skid_v_reg, skid_v_next;
    btpc_pkg::res_t out_d_reg, out_d_next;
    btpc_pkg::res_t skid_d_reg, skid_d_next;
    logic out_free;

    always_comb begin
        out_free    = !out_v_reg || m_tready;
        out_v_next  = out_v_reg;
        out_d_next  = out_d_reg;
        skid_v_next = skid_v_reg;
        skid_d_next = skid_d_reg;
        if (skid_v_reg) begin
            if (out_free) begin
                out_v_next  = 1'b1;
                out_d_next  = skid_d_reg;
                skid_v_next = 1'b0;
            end
        end else if (out_free) begin
            out_v_next = in_valid;
            out_d_next = in_data;
        end else if (in_valid) begin
            skid_v_next = 1'b1;
            skid_d_next = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_d_reg  <= out_d_next;
        skid_d_reg <= skid_d_next;
    end

    assign adv     = !skid_v_reg;
    assign m_valid = out_v_reg;
    assign m_data  = out_d_reg;

endmodule
`default_nettype wire

// File: src/baro_temp_pressure_compensation_unit.sv
// Top level: calibration registers and the temperature/pressure compensation pipeline.
//
// Usage:
//   Write the four calibration registers on the cfg channel (index 0 temperature
//   coefficients, 1..3 pressure coefficients; other indexes are dropped) while no
//   transfer is in flight. cfg_ready is high whenever reset is released.
//   Each s_ transfer carries one raw temperature and one raw pressure reading and
//   yields exactly one m_ transfer: temperature in 0.01 degC, fine temperature,
//   pressure in Pa (Q17.8) and, on m_tuser, a pressure-valid flag that is low when
//   the pressure divisor came out zero.
//   One transfer is taken every cycle while s_tready is high. The pipeline ahead
//   of the output register has 34 register stages, of which 16 form the divider
//   retiring four quotient bits each.
//   When m_tready is low the output register holds its result and one more result
//   lands in a skid register; the pipeline then holds and s_tready drops until the
//   skid entry drains. Nothing is lost or repeated.
//   Reset clears every calibration register to zero and empties the pipeline;
//   s_tready and cfg_ready stay low while reset is held.
`default_nettype none
module baro_temp_pressure_compensation_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // raw_temperature [19:0], raw_pressure [39:20]
    input  wire logic [btpc_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // temperature_centi [14:0], fine_temperature [34:15], pressure_q17_8 [59:35], zero [63:60]
    output logic [btpc_pkg::M_TDATA_W-1:0]           m_tdata,
    // pressure_valid [0]
    output logic                                     m_tuser,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [btpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [btpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [btpc_pkg::CFG_DATA_W-1:0] temp_cfg_reg, plo_cfg_reg, pmid_cfg_reg, phi_cfg_reg;
    btpc_pkg::coef_t  coef;
    logic             adv;
    logic             t_valid, p_valid, d_valid, r_valid;
    btpc_pkg::tout_t  t_data;
    btpc_pkg::dvin_t  p_data;
    btpc_pkg::dvout_t d_data;
    btpc_pkg::res_t   r_data, m_data;

    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_cfg_reg <= '0;
            plo_cfg_reg  <= '0;
            pmid_cfg_reg <= '0;
            phi_cfg_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                btpc_pkg::REG_TEMP: temp_cfg_reg <= cfg_data;
                btpc_pkg::REG_PLO:  plo_cfg_reg  <= cfg_data;
                btpc_pkg::REG_PMID: pmid_cfg_reg <= cfg_data;
                btpc_pkg::REG_PHI:  phi_cfg_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign coef.t1 = temp_cfg_reg[15:0];
    assign coef.t2 = temp_cfg_reg[31:16];
    assign coef.t3 = temp_cfg_reg[47:32];
    assign coef.p1 = plo_cfg_reg[15:0];
    assign coef.p2 = plo_cfg_reg[31:16];
    assign coef.p3 = plo_cfg_reg[47:32];
    assign coef.p4 = pmid_cfg_reg[15:0];
    assign coef.p5 = pmid_cfg_reg[31:16];
    assign coef.p6 = pmid_cfg_reg[47:32];
    assign coef.p7 = phi_cfg_reg[15:0];
    assign coef.p8 = phi_cfg_reg[31:16];
    assign coef.p9 = phi_cfg_reg[47:32];

    assign s_tready = adv && aresetn;

    btpc_temp u_temp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid && s_tready),
        .in_at     (s_tdata[19:0]),
        .in_ap     (s_tdata[39:20]),
        .coef      (coef),
        .out_valid (t_valid),
        .out_data  (t_data)
    );

    btpc_press u_press (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (t_valid),
        .in_data   (t_data),
        .coef      (coef),
        .out_valid (p_valid),
        .out_data  (p_data)
    );

    btpc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (p_valid),
        .in_data   (p_data),
        .out_valid (d_valid),
        .out_data  (d_data)
    );

    btpc_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (d_valid),
        .in_data   (d_data),
        .coef      (coef),
        .out_valid (r_valid),
        .out_data  (r_data)
    );

    btpc_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (r_valid),
        .in_data  (r_data),
        .m_tready (m_tready),
        .adv      (adv),
        .m_valid  (m_tvalid),
        .m_data   (m_data)
    );

    assign m_tdata = {4'b0000, m_data.pres, m_data.tf, m_data.tc};
    assign m_tuser = m_data.pvld;

endmodule
`default_nettype wire
